// ===== design/spcc_pkg.sv =====
package spcc_pkg;

	localparam int unsigned CoordW  = 32;
	localparam int unsigned DiffW   = 33;
	localparam int unsigned MagW    = 32;
	localparam int unsigned SumW    = 66;
	localparam int unsigned RootW   = 33;
	localparam int unsigned RemW    = 35;
	localparam int unsigned QuotW   = 31;
	localparam int unsigned NumW    = 63;
	localparam int unsigned RadiusW = 31;
	localparam int unsigned IdxW    = 3;

	typedef enum logic [IdxW-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_VEL_X    = 3'd3,
		REG_VEL_Y    = 3'd4,
		REG_VEL_Z    = 3'd5,
		REG_RADIUS   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [CoordW-1:0] point_x;
		logic signed [CoordW-1:0] point_y;
		logic signed [CoordW-1:0] point_z;
		logic signed [CoordW-1:0] point_vel_x;
		logic signed [CoordW-1:0] point_vel_y;
		logic signed [CoordW-1:0] point_vel_z;
	} in_item_t;

	typedef struct packed {
		logic                     contact;
		logic signed [CoordW-1:0] overlap;
		logic signed [CoordW-1:0] approach_speed;
		logic signed [CoordW-1:0] dir_x;
		logic signed [CoordW-1:0] dir_y;
		logic signed [CoordW-1:0] dir_z;
	} out_item_t;

	typedef struct packed {
		logic [IdxW-1:0]   index;
		logic [CoordW-1:0] data;
	} cfg_item_t;

endpackage

// ===== design/spcc_chan_if.sv =====
interface spcc_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/spcc_sqrt_pipe.sv =====
// one root bit per stage, restoring square root over a stalled pipeline
module spcc_sqrt_pipe
	import spcc_pkg::*;
#(
	parameter type side_t = logic
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [SumW-1:0]   in_sum,
	input  side_t             in_side,
	output logic              out_valid,
	output logic [RootW-1:0]  out_root,
	output side_t             out_side
);
	localparam int unsigned Steps = RootW;

	logic              vld_s  [Steps+1];
	logic [SumW-1:0]   sum_s  [Steps+1];
	logic [RootW-1:0]  root_s [Steps+1];
	logic [RemW-1:0]   rem_s  [Steps+1];
	side_t             side_s [Steps+1];

	assign vld_s[0]  = in_valid;
	assign sum_s[0]  = in_sum;
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [RemW-1:0]  rem_sh;
		logic [RemW-1:0]  trial;
		logic             take;

		always_comb begin
			rem_sh = {rem_s[k][RemW-3:0], sum_s[k][SumW-1:SumW-2]};
			trial  = {root_s[k][RemW-3:0], 2'b01};
			take   = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sum_s[k+1]  <= {sum_s[k][SumW-3:0], 2'b00};
				rem_s[k+1]  <= take ? rem_sh - trial : rem_sh;
				root_s[k+1] <= {root_s[k][RootW-2:0], take};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[Steps];
	assign out_root  = root_s[Steps];
	assign out_side  = side_s[Steps];
endmodule

// ===== design/spcc_div_pipe.sv =====
// one quotient bit per stage, restoring divide of three numerators by one divisor
module spcc_div_pipe
	import spcc_pkg::*;
#(
	parameter type side_t = logic
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NumW-1:0]   in_num [3],
	input  logic [RootW-1:0]  in_den,
	input  side_t             in_side,
	output logic              out_valid,
	output logic [QuotW-1:0]  out_quot [3],
	output side_t             out_side
);
	localparam int unsigned Steps = QuotW;
	localparam int unsigned PartW = RootW + 1;

	logic              vld_s  [Steps+1];
	logic [NumW-1:0]   num_s  [Steps+1][3];
	logic [PartW-1:0]  rem_s  [Steps+1][3];
	logic [QuotW-1:0]  quot_s [Steps+1][3];
	logic [RootW-1:0]  den_s  [Steps+1];
	side_t             side_s [Steps+1];

	assign vld_s[0]  = in_valid;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	// the top 32 numerator bits always stay below the divisor, so they seed the remainder
	for (genvar j = 0; j < 3; j++) begin : g_seed
		assign num_s[0][j]  = {in_num[j][Steps-1:0], {(NumW-Steps){1'b0}}};
		assign rem_s[0][j]  = {2'b00, in_num[j][NumW-1:Steps]};
		assign quot_s[0][j] = '0;
	end

	for (genvar k = 0; k < Steps; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		for (genvar j = 0; j < 3; j++) begin : g_lane
			logic [PartW-1:0] part;
			logic             take;

			always_comb begin
				part = {rem_s[k][j][PartW-2:0], num_s[k][j][NumW-1]};
				take = part >= {1'b0, den_s[k]};
			end

			always_ff @(posedge clk) begin
				if (en) begin
					num_s[k+1][j]  <= {num_s[k][j][NumW-2:0], 1'b0};
					rem_s[k+1][j]  <= take ? part - {1'b0, den_s[k]} : part;
					quot_s[k+1][j] <= {quot_s[k][j][QuotW-2:0], take};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[Steps];
	assign out_quot  = quot_s[Steps];
	assign out_side  = side_s[Steps];
endmodule

// ===== design/sphere_point_contact_check.sv =====
// sphere_point_contact_check: one point against a configured sphere
// stages in order: s1 to s3, the root pipe, the divide pipe, s4, s5 and the output register
// throughput: one request per cycle while the output is not stalled, set by the one-bit-per-stage root and divide pipes
// a stall holds every stage in place; the output register frees as soon as it is taken
// reset: arst_n clears all valid bits and zeroes the seven configuration registers
module sphere_point_contact_check
	import spcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	spcc_chan_if.sink   in_ch,
	spcc_chan_if.source out_ch,
	spcc_chan_if.sink   cfg_ch
);
	// items carried beside the root and divide pipes
	typedef struct packed {
		logic              zero;
		logic [2:0]        neg;
		logic [MagW-1:0]   mag_x;
		logic [MagW-1:0]   mag_y;
		logic [MagW-1:0]   mag_z;
		logic signed [DiffW-1:0] rv_x;
		logic signed [DiffW-1:0] rv_y;
		logic signed [DiffW-1:0] rv_z;
	} side_a_t;

	typedef struct packed {
		logic              zero;
		logic [2:0]        neg;
		logic [RootW-1:0]  radial;
		logic signed [DiffW-1:0] rv_x;
		logic signed [DiffW-1:0] rv_y;
		logic signed [DiffW-1:0] rv_z;
	} side_b_t;

	//------------------------------------------------------------------
	// configuration registers
	//------------------------------------------------------------------
	logic signed [CoordW-1:0] center_q [3];
	logic signed [CoordW-1:0] svel_q   [3];
	logic [RadiusW-1:0]       radius_q;
	cfg_item_t                cfg;

	assign cfg          = cfg_ch.data;
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '{default: '0};
			svel_q   <= '{default: '0};
			radius_q <= '0;
		end else if (cfg_ch.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_CENTER_X: center_q[0] <= cfg.data;
				REG_CENTER_Y: center_q[1] <= cfg.data;
				REG_CENTER_Z: center_q[2] <= cfg.data;
				REG_VEL_X:    svel_q[0]   <= cfg.data;
				REG_VEL_Y:    svel_q[1]   <= cfg.data;
				REG_VEL_Z:    svel_q[2]   <= cfg.data;
				REG_RADIUS:   radius_q    <= cfg.data[RadiusW-1:0];
				default:      ; // writes beyond the list are dropped
			endcase
		end
	end

	//------------------------------------------------------------------
	// global stall: the whole pipe advances unless the output is blocked
	//------------------------------------------------------------------
	logic en;
	logic out_vld_q;
	assign en          = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	in_item_t pin;
	assign pin = in_ch.data;

	//------------------------------------------------------------------
	// s1: differences to center and relative velocity
	//------------------------------------------------------------------
	logic                    vld_s1;
	logic signed [DiffW-1:0] d_s1  [3];
	logic signed [DiffW-1:0] rv_s1 [3];
	logic signed [CoordW-1:0] pp [3];
	logic signed [CoordW-1:0] pv [3];

	assign pp = '{pin.point_x, pin.point_y, pin.point_z};
	assign pv = '{pin.point_vel_x, pin.point_vel_y, pin.point_vel_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i]  <= DiffW'(pp[i]) - DiffW'(center_q[i]);
				rv_s1[i] <= DiffW'(svel_q[i]) - DiffW'(pv[i]);
			end
		end
	end

	//------------------------------------------------------------------
	// s2: magnitudes and squares
	//------------------------------------------------------------------
	logic                    vld_s2;
	logic [MagW-1:0]         mag_s2 [3];
	logic [2*MagW-1:0]       sq_s2  [3];
	logic [2:0]              neg_s2;
	logic signed [DiffW-1:0] rv_s2  [3];
	logic [MagW-1:0]         mag_c  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = d_s1[i][DiffW-1] ? MagW'(-d_s1[i]) : MagW'(d_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= mag_c[i];
				sq_s2[i]  <= mag_c[i] * mag_c[i];
				neg_s2[i] <= d_s1[i][DiffW-1];
				rv_s2[i]  <= rv_s1[i];
			end
		end
	end

	//------------------------------------------------------------------
	// s3: sum of squares, zero detect
	//------------------------------------------------------------------
	logic              vld_s3;
	logic [SumW-1:0]   sum_s3;
	side_a_t           side_s3;
	logic [SumW-1:0]   sum_c;

	assign sum_c = SumW'(sq_s2[0]) + SumW'(sq_s2[1]) + SumW'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3        <= sum_c;
			side_s3.zero  <= (mag_s2[0] == '0) && (mag_s2[1] == '0) && (mag_s2[2] == '0);
			side_s3.neg   <= neg_s2;
			side_s3.mag_x <= mag_s2[0];
			side_s3.mag_y <= mag_s2[1];
			side_s3.mag_z <= mag_s2[2];
			side_s3.rv_x  <= rv_s2[0];
			side_s3.rv_y  <= rv_s2[1];
			side_s3.rv_z  <= rv_s2[2];
		end
	end

	//------------------------------------------------------------------
	// distance: floor square root
	//------------------------------------------------------------------
	logic              vld_r;
	logic [RootW-1:0]  root_r;
	side_a_t           side_r;

	spcc_sqrt_pipe #(.side_t(side_a_t)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_sum    (sum_s3),
		.in_side   (side_s3),
		.out_valid (vld_r),
		.out_root  (root_r),
		.out_side  (side_r)
	);

	// rounded divide: numerator |d|*2^30 + dist/2, divisor forced to 1 at the center
	logic [NumW-1:0]   num_c [3];
	logic [RootW-1:0]  den_c;
	side_b_t           side_b;

	always_comb begin
		den_c = side_r.zero ? RootW'(1) : root_r;
		num_c[0] = {side_r.mag_x, 31'd0} >> 1;
		num_c[1] = {side_r.mag_y, 31'd0} >> 1;
		num_c[2] = {side_r.mag_z, 31'd0} >> 1;
		for (int i = 0; i < 3; i++) begin
			num_c[i] = num_c[i] + NumW'(den_c >> 1);
		end
		side_b.zero   = side_r.zero;
		side_b.neg    = side_r.neg;
		side_b.radial = root_r;
		side_b.rv_x   = side_r.rv_x;
		side_b.rv_y   = side_r.rv_y;
		side_b.rv_z   = side_r.rv_z;
	end

	logic              vld_q;
	logic [QuotW-1:0]  quot_q [3];
	side_b_t           side_q;

	spcc_div_pipe #(.side_t(side_b_t)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_r),
		.in_num    (num_c),
		.in_den    (den_c),
		.in_side   (side_b),
		.out_valid (vld_q),
		.out_quot  (quot_q),
		.out_side  (side_q)
	);

	//------------------------------------------------------------------
	// s4: signed direction, overlap, contact
	//------------------------------------------------------------------
	logic                     vld_s4;
	logic signed [CoordW-1:0] dir_s4 [3];
	logic signed [CoordW-1:0] ovl_s4;
	logic                     contact_s4;
	logic                     zero_s4;
	logic signed [DiffW-1:0]  rv_s4  [3];
	logic signed [RootW+1:0]  ovl_c;
	logic signed [CoordW-1:0] ovl_sat;

	always_comb begin
		ovl_c = (RootW+2)'(radius_q) - (RootW+2)'(side_q.radial);
		if (ovl_c > (RootW+2)'(32'sh7fffffff)) begin
			ovl_sat = 32'sh7fffffff;
		end else if (ovl_c < -(RootW+2)'(33'sh080000000)) begin
			ovl_sat = 32'sh80000000;
		end else begin
			ovl_sat = ovl_c[CoordW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dir_s4[i] <= side_q.zero ? '0 :
					side_q.neg[i] ? -CoordW'(quot_q[i]) : CoordW'(quot_q[i]);
			end
			ovl_s4     <= side_q.zero ? '0 : ovl_sat;
			contact_s4 <= !side_q.zero && !ovl_sat[CoordW-1];
			zero_s4    <= side_q.zero;
			rv_s4[0]   <= side_q.rv_x;
			rv_s4[1]   <= side_q.rv_y;
			rv_s4[2]   <= side_q.rv_z;
		end
	end

	//------------------------------------------------------------------
	// s5: three products rv * dir
	//------------------------------------------------------------------
	logic                         vld_s5;
	logic signed [DiffW+CoordW-1:0] prod_s5 [3];
	logic signed [CoordW-1:0]     dir_s5 [3];
	logic signed [CoordW-1:0]     ovl_s5;
	logic                         contact_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= rv_s4[i] * dir_s4[i];
			end
			dir_s5     <= dir_s4;
			ovl_s5     <= ovl_s4;
			contact_s5 <= contact_s4 && !zero_s4;
		end
	end

	//------------------------------------------------------------------
	// s6: sum, round half up, saturate; output register
	//------------------------------------------------------------------
	localparam int unsigned AccW = DiffW + CoordW + 2;
	logic signed [AccW-1:0]   acc_c;
	logic signed [AccW-31:0]  sh_c;
	logic signed [CoordW-1:0] spd_c;
	out_item_t                res_q;

	always_comb begin
		acc_c = AccW'(prod_s5[0]) + AccW'(prod_s5[1]) + AccW'(prod_s5[2])
			+ AccW'(64'sd536870912);
		sh_c  = acc_c[AccW-1:30];
		if (sh_c > (AccW-30)'(32'sh7fffffff)) begin
			spd_c = 32'sh7fffffff;
		end else if (sh_c < -(AccW-30)'(33'sh080000000)) begin
			spd_c = 32'sh80000000;
		end else begin
			spd_c = sh_c[CoordW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.contact        <= contact_s5;
			res_q.overlap        <= ovl_s5;
			res_q.approach_speed <= contact_s5 ? spd_c : '0;
			res_q.dir_x          <= dir_s5[0];
			res_q.dir_y          <= dir_s5[1];
			res_q.dir_z          <= dir_s5[2];
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.data  = res_q;

	//------------------------------------------------------------------
	// checks
	//------------------------------------------------------------------
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed while stalled");

	a_no_contact_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !res_q.contact |-> res_q.approach_speed == '0)
		else $error("approach speed without contact");

	a_contact_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && res_q.contact |-> !res_q.overlap[CoordW-1])
		else $error("contact with negative overlap");

	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		!out_ch.valid |-> in_ch.ready)
		else $error("input blocked with empty output");
endmodule

// ===== sim/tb.sv =====
module tb;
	import spcc_pkg::*;

	logic clk;
	logic arst_n;

	spcc_chan_if #(.payload_t(in_item_t))  in_ch ();
	spcc_chan_if #(.payload_t(out_item_t)) out_ch ();
	spcc_chan_if #(.payload_t(cfg_item_t)) cfg_ch ();

	sphere_point_contact_check u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	// pipeline depth from request accept to result, plus margin for the drain
	localparam int DrainCycles = 100;

	// shadow copy of the sphere registers
	logic signed [31:0] sph_center [3];
	logic signed [31:0] sph_vel [3];
	logic [30:0]        sph_radius;

	out_item_t contact_q [$];
	int        mismatch_cnt;
	int        unexpected_cnt;
	int        gap_mode;   // 0 none, 1 short gaps, 2 mixed with long
	int        stall_left;

	initial begin
		clk = 1'b0;
	end
	always #6 clk = ~clk;

	// floor square root of a 66-bit sum of squares
	function automatic logic [32:0] floor_root(logic [65:0] val);
		logic [32:0] root;
		logic [35:0] rem;
		logic [35:0] trial;
		root = '0;
		rem  = '0;
		for (int k = 32; k >= 0; k--) begin
			rem   = {rem[33:0], val[2*k+1 -: 2]};
			trial = {1'b0, root, 2'b01};
			if (rem >= trial) begin
				rem  = rem - trial;
				root = {root[31:0], 1'b1};
			end else begin
				root = {root[31:0], 1'b0};
			end
		end
		return root;
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return 32'sh7fffffff;
		if (v < -128'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// expected contact result for one point against the current sphere
	function automatic out_item_t predict_contact(in_item_t pt);
		out_item_t          res;
		logic signed [32:0] diff [3];
		logic [32:0]        mag [3];
		logic [65:0]        sumsq;
		logic [32:0]        radial;
		logic [63:0]        q;
		logic signed [31:0] dirv [3];
		logic signed [127:0] acc;
		logic signed [127:0] ovl;
		logic signed [31:0] pos [3];
		logic signed [31:0] pvel [3];
		pos  = '{pt.point_x, pt.point_y, pt.point_z};
		pvel = '{pt.point_vel_x, pt.point_vel_y, pt.point_vel_z};
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			diff[i] = 33'(pos[i]) - 33'(sph_center[i]);
			mag[i]  = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
			sumsq  += 66'(mag[i]) * 66'(mag[i]);
		end
		res = '0;
		if (sumsq == '0)
			return res;
		radial = floor_root(sumsq);
		for (int i = 0; i < 3; i++) begin
			q = ((64'(mag[i]) << 30) + 64'(radial >> 1)) / 64'(radial);
			dirv[i] = diff[i][32] ? -$signed(q[31:0]) : $signed(q[31:0]);
		end
		ovl = $signed({97'd0, sph_radius}) - $signed({95'd0, radial});
		res.overlap = clamp32(ovl);
		res.contact = !res.overlap[31];
		res.dir_x = dirv[0];
		res.dir_y = dirv[1];
		res.dir_z = dirv[2];
		if (res.contact) begin
			acc = '0;
			for (int i = 0; i < 3; i++)
				acc += (128'(sph_vel[i]) - 128'(pvel[i])) * 128'(dirv[i]);
			// round half up from Q.30 to Q32.0, the velocity scale
			acc = (acc + (128'sd1 <<< 29)) >>> 30;
			res.approach_speed = clamp32(acc);
		end
		return res;
	endfunction

	// random gap length, mostly short with a few long ones
	function automatic int gap_len();
		int n;
		if (gap_mode == 0)
			return 0;
		n = $urandom_range(0, 99);
		if (n < 55)
			n = 0;
		else if (n < 95 || gap_mode == 1)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 40);
		return n;
	endfunction

	// register write, only while the block has nothing in flight
	// valid stays up so the next write can follow directly
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_CENTER_X: sph_center[0] = val;
			REG_CENTER_Y: sph_center[1] = val;
			REG_CENTER_Z: sph_center[2] = val;
			REG_VEL_X:    sph_vel[0] = val;
			REG_VEL_Y:    sph_vel[1] = val;
			REG_VEL_Z:    sph_vel[2] = val;
			REG_RADIUS:   sph_radius = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic [30:0] rad);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_VEL_X, vx);
		write_reg(REG_VEL_Y, vy);
		write_reg(REG_VEL_Z, vz);
		write_reg(REG_RADIUS, {1'b0, rad});
		cfg_ch.valid <= 1'b0;
	endtask

	// one request; the expectation is queued at the accepting edge
	// valid stays up so a request with no gap follows directly
	task automatic send_point(in_item_t pt);
		int n;
		n = gap_len();
		if (n > 0) begin
			in_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= pt;
		do @(posedge clk); while (!in_ch.ready);
		contact_q.push_back(predict_contact(pt));
	endtask

	// drop valid and hold off until every result is back
	task automatic wait_results();
		in_ch.valid <= 1'b0;
		while (contact_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		wait_results();
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic in_item_t rand_point(bit near);
		in_item_t   pt;
		logic [31:0] span;
		pt = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		if (near) begin
			// cluster around the center so contacts are common
			span = 32'd1 << $urandom_range(4, 30);
			pt.point_x = sph_center[0] + $signed($urandom_range(0, span)) - $signed(span >> 1);
			pt.point_y = sph_center[1] + $signed($urandom_range(0, span)) - $signed(span >> 1);
			pt.point_z = sph_center[2] + $signed($urandom_range(0, span)) - $signed(span >> 1);
		end
		return pt;
	endfunction

	// ---------------- tests ----------------

	// corners of the fields, center hit, far point, axis points
	task automatic test_directed();
		in_item_t pt;
		gap_mode = 0;
		// reset state: sphere at origin with zero radius
		pt = '0;
		send_point(pt);
		pt.point_x = 32'sd1;
		send_point(pt);
		wait_drained();
		set_sphere(32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h80000000, 32'h0, 31'h7fffffff);
		pt = '0;
		pt.point_vel_x = 32'sh80000000;
		pt.point_vel_y = 32'sh7fffffff;
		send_point(pt);
		pt.point_x = 32'sh20000000;
		send_point(pt);
		pt.point_x = 32'sh7fffffff; pt.point_y = 32'sh7fffffff; pt.point_z = 32'sh7fffffff;
		send_point(pt);
		pt.point_x = -32'sd1; pt.point_y = 32'sd0; pt.point_z = 32'sd0;
		send_point(pt);
		pt.point_y = 32'sd1; pt.point_z = -32'sd1;
		send_point(pt);
		wait_drained();
		// opposite corners: biggest difference, far outside
		set_sphere(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h80000000, 31'h0);
		pt = {32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
		send_point(pt);
		pt.point_x = 32'sh7fffffff; pt.point_y = 32'sh7fffffff; pt.point_z = 32'sh7fffffff;
		send_point(pt);
		pt.point_z = 32'sh7ffffffe;
		send_point(pt);
		pt.point_y = 32'sh80000000;
		send_point(pt);
		wait_drained();
		// exact touch at the surface, one step inside and outside
		set_sphere(32'h80000000, 32'h0, 32'h12345678, 32'h00800000, 32'hff800000,
			32'h0, 31'h20000000);
		pt = '0;
		pt.point_x = 32'sh80000000 + 32'sh20000000;
		pt.point_z = 32'sh12345678;
		pt.point_vel_x = -32'sh00800000;
		send_point(pt);
		pt.point_x = pt.point_x + 32'sd1;
		send_point(pt);
		pt.point_x = pt.point_x - 32'sd2;
		send_point(pt);
		pt.point_x = 32'sh80000000; pt.point_y = 32'sh80000000;
		send_point(pt);
		pt = {32'sh80000000, 32'sh0, 32'sh12345678, 32'sh0, 32'sh0, 32'sh0};
		send_point(pt);
		wait_drained();
	endtask

	// random points under one random sphere setting per call, extreme radii among the calls
	task automatic test_random(int n_items, logic [30:0] rad, int modes);
		set_sphere($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, rad);
		for (int i = 0; i < n_items; i++) begin
			gap_mode = (i % 60 < 15) ? 0 : modes;
			send_point(rand_point($urandom_range(0, 3) != 0));
			// sender holds off until every result is back
			if (i == n_items / 2)
				wait_results();
		end
		wait_drained();
	endtask

	// ---------------- result checker ----------------

	// random receiver stalls, mostly short with a few long ones
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else begin
			case ($urandom_range(0, 99))
				0, 1: begin
					stall_left = $urandom_range(8, 40);
					out_ch.ready <= 1'b0;
				end
				2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19:
					out_ch.ready <= 1'b0;
				default: out_ch.ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		out_item_t exp_res;
		out_item_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (contact_q.size() == 0) begin
				unexpected_cnt++;
				if (mismatch_cnt + unexpected_cnt <= 10)
					$display("result with no request pending: %p", got);
			end else begin
				exp_res = contact_q.pop_front();
				if (got !== exp_res) begin
					mismatch_cnt++;
					if (mismatch_cnt + unexpected_cnt <= 10)
						$display("mismatch: expected %p, got %p", exp_res, got);
				end
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data  = '0;
		mismatch_cnt = 0;
		unexpected_cnt = 0;
		gap_mode     = 0;
		sph_center   = '{32'sd0, 32'sd0, 32'sd0};
		sph_vel      = '{32'sd0, 32'sd0, 32'sd0};
		sph_radius   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(250, 31'h7fffffff, 2);
		test_random(250, 31'($urandom_range(0, 31'h3fffffff)), 1);
		test_random(250, 31'h0, 2);

		if (mismatch_cnt == 0 && unexpected_cnt == 0 && contact_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
